@@ rtl/fcfs_rr_pkg.sv @@
// Shared types and constants for the FCFS / round-robin tick scheduler.
// Holds the controller state type and the command and status bundles.
// No dependencies.
package fcfs_rr_pkg;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int MODE_W    = 2;
  localparam int IN_W      = 16;
  localparam int IN_BURST_W = 10;
  localparam int OUT_W     = 80;
  localparam int GRANT_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 22;
  localparam int CLOCK_W   = 16;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_UPDATE,
    ST_SUM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_add;
    logic reject;
    logic do_clear;
    logic scan_start;
    logic scan_step;
    logic mem_read;
    logic update;
    logic sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              table_full;
    logic              sched_idle;
    logic              scan_hit;
  } status_t;

endpackage

@@ rtl/fcfs_round_robin_tick_scheduler_unit.sv @@
// Top level of the FCFS / round-robin tick scheduler.
// Joins fcfs_rr_ctrl and fcfs_rr_dp; uses fcfs_rr_pkg.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | in_tdata[9:0] burst_time, in_tuser[1:0] mode
//   out_    | out | out_tvalid/out_tready | out_tdata (fields listed at the port)
//   cfg_    | in  | cfg_wr_en           | cfg_wr_data algorithm
//
// Add, clear, unused modes and a tick with nothing to run pass through accept,
// decode and result load. A tick that grants adds scan, update and sum between
// decode and result load; the scan steps past one done bit per cycle, up to the
// process count minus one entries.
// Synchronous active-low reset; no clearing pass, the table starts empty.
// A result waits in the output register; the next item is accepted meanwhile
// and holds in the final state only while the previous result is not taken.
module fcfs_round_robin_tick_scheduler_unit #(
  parameter int MAX_PROCESSES = 64,
  parameter int BURST_BITS    = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] burst_time, [15:10] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [0] slot_valid, [6:1] granted_process,
                                  // [7] process_finished, [8] schedule_done,
                                  // [9] table_full, [16:10] process_count,
                                  // [38:17] total_wait, [60:39] total_turnaround,
                                  // [76:61] elapsed_time, [79:77] zero
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  fcfs_rr_pkg::cmd_t    cmd;
  fcfs_rr_pkg::status_t sts;

  fcfs_rr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fcfs_rr_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .BURST_BITS    (BURST_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tdata   (out_tdata)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while pending");

  a_add_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_add |-> !sts.table_full)
    else $error("add written into a full table");

  a_finish_needs_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> !out_tdata[7])
    else $error("process finished without a grant");

  a_scan_only_when_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !sts.sched_idle)
    else $error("scan started with no unfinished process");
`endif

endmodule

@@ rtl/fcfs_rr_ctrl.sv @@
// Controller state machine for the tick scheduler.
// Sequences decode, table scan, update and result hand-off; uses fcfs_rr_pkg.
module fcfs_rr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  fcfs_rr_pkg::status_t sts,
  output fcfs_rr_pkg::cmd_t    cmd
);

  fcfs_rr_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == fcfs_rr_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcfs_rr_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = fcfs_rr_pkg::ST_DECODE;
      end
      fcfs_rr_pkg::ST_DECODE: begin
        if (sts.mode == fcfs_rr_pkg::MODE_TICK && !sts.sched_idle)
          state_nxt = fcfs_rr_pkg::ST_SCAN;
        else
          state_nxt = fcfs_rr_pkg::ST_RESP;
      end
      fcfs_rr_pkg::ST_SCAN: begin
        if (sts.scan_hit) state_nxt = fcfs_rr_pkg::ST_UPDATE;
      end
      fcfs_rr_pkg::ST_UPDATE: state_nxt = fcfs_rr_pkg::ST_SUM;
      fcfs_rr_pkg::ST_SUM:    state_nxt = fcfs_rr_pkg::ST_RESP;
      fcfs_rr_pkg::ST_RESP: begin
        if (out_free) state_nxt = fcfs_rr_pkg::ST_IDLE;
      end
      default: state_nxt = fcfs_rr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      fcfs_rr_pkg::ST_IDLE: begin
        cmd.load_item = in_tvalid;
      end
      fcfs_rr_pkg::ST_DECODE: begin
        unique case (sts.mode)
          fcfs_rr_pkg::MODE_ADD: begin
            cmd.reject = sts.table_full;
            cmd.do_add = !sts.table_full;
          end
          fcfs_rr_pkg::MODE_TICK:  cmd.scan_start = !sts.sched_idle;
          fcfs_rr_pkg::MODE_CLEAR: cmd.do_clear = 1'b1;
          default: ;
        endcase
      end
      fcfs_rr_pkg::ST_SCAN: begin
        cmd.mem_read  = sts.scan_hit;
        cmd.scan_step = !sts.scan_hit;
      end
      fcfs_rr_pkg::ST_UPDATE: cmd.update = 1'b1;
      fcfs_rr_pkg::ST_SUM:    cmd.sum = 1'b1;
      fcfs_rr_pkg::ST_RESP:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcfs_rr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/fcfs_rr_dp.sv @@
// Datapath for the tick scheduler: burst and served-tick memories, done bits,
// scan pointer, timeline counters and the result register; uses fcfs_rr_pkg.
module fcfs_rr_dp #(
  parameter int MAX_PROCESSES = 64,
  parameter int BURST_BITS    = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [fcfs_rr_pkg::IN_W-1:0]          in_tdata,
  input  logic [fcfs_rr_pkg::MODE_W-1:0]        in_tuser,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  fcfs_rr_pkg::cmd_t                     cmd,
  output fcfs_rr_pkg::status_t                  sts,
  output logic [fcfs_rr_pkg::OUT_W-1:0]         out_tdata
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int NW    = IDX_W + 1;
  localparam int CW    = fcfs_rr_pkg::CLOCK_W;
  localparam int SW    = fcfs_rr_pkg::SUM_W;
  localparam logic [NW-1:0]    MAX_CNT  = NW'(MAX_PROCESSES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);

  logic [BURST_BITS-1:0] burst_mem  [MAX_PROCESSES];
  logic [BURST_BITS-1:0] served_mem [MAX_PROCESSES];

  logic                         alg_r;
  logic [fcfs_rr_pkg::MODE_W-1:0] mode_r;
  logic [BURST_BITS-1:0]        burst_r;
  logic [BURST_BITS-1:0]        burst_rd_r;
  logic [BURST_BITS-1:0]        served_rd_r;
  logic [NW-1:0]                count_r, nz_r, unfin_r;
  logic [IDX_W-1:0]             last_r, scan_idx_r, granted_r;
  logic [MAX_PROCESSES-1:0]     done_r, zb_r, touched_r;
  logic [CW-1:0]                clock_r;
  logic [SW-1:0]                wait_r, turn_r;
  logic                         grant_r, fin_r, full_r, fin_hit_r;
  logic [fcfs_rr_pkg::OUT_W-1:0] out_r;

  logic [BURST_BITS+fcfs_rr_pkg::IN_BURST_W-1:0] burst_in_ext;
  logic [BURST_BITS-1:0]        burst_in;
  logic [IDX_W-1:0]             add_idx;
  logic [MAX_PROCESSES-1:0]     zb_add;
  logic [NW-1:0]                nz_add;
  logic [NW-1:0]                last_inc, step_inc;
  logic [IDX_W-1:0]             start_idx, step_next;
  logic [BURST_BITS-1:0]        served_cur, served_new;
  logic [CW-1:0]                clock_inc;
  logic [BURST_BITS+CW-1:0]     burst_ext;
  logic [CW-1:0]                burst16, wait_amt;
  logic [SW:0]                  turn_add, wait_add;
  logic [SW-1:0]                turn_sat, wait_sat;
  logic [IDX_W+fcfs_rr_pkg::GRANT_W-1:0] granted_ext;
  logic [NW+fcfs_rr_pkg::COUNT_W-1:0]    count_ext;

  assign burst_in_ext = {{BURST_BITS{1'b0}}, in_tdata[fcfs_rr_pkg::IN_BURST_W-1:0]};
  assign burst_in     = burst_in_ext[BURST_BITS-1:0];
  assign add_idx      = count_r[IDX_W-1:0];

  always_comb begin
    zb_add          = zb_r;
    zb_add[add_idx] = (burst_r == '0);
  end

  assign nz_add    = nz_r + NW'(burst_r != '0);
  assign last_inc  = {1'b0, last_r} + NW'(1);
  assign start_idx = (alg_r && last_inc < count_r) ? last_inc[IDX_W-1:0] : '0;
  assign step_inc  = {1'b0, scan_idx_r} + NW'(1);
  assign step_next = (step_inc < count_r) ? step_inc[IDX_W-1:0] : '0;

  assign served_cur = touched_r[scan_idx_r] ? served_rd_r : '0;
  assign served_new = served_cur + BURST_BITS'(1);
  assign clock_inc  = (clock_r == fcfs_rr_pkg::CLOCK_MAX) ? clock_r : clock_r + CW'(1);

  assign burst_ext = {{CW{1'b0}}, burst_rd_r};
  assign burst16   = burst_ext[CW-1:0];
  assign wait_amt  = (clock_r >= burst16) ? clock_r - burst16 : '0;
  assign turn_add  = {1'b0, turn_r} + {{(SW+1-CW){1'b0}}, clock_r};
  assign wait_add  = {1'b0, wait_r} + {{(SW+1-CW){1'b0}}, wait_amt};
  assign turn_sat  = turn_add[SW] ? fcfs_rr_pkg::SUM_MAX : turn_add[SW-1:0];
  assign wait_sat  = wait_add[SW] ? fcfs_rr_pkg::SUM_MAX : wait_add[SW-1:0];

  assign granted_ext = {{fcfs_rr_pkg::GRANT_W{1'b0}}, granted_r};
  assign count_ext   = {{fcfs_rr_pkg::COUNT_W{1'b0}}, count_r};

  assign sts.mode       = mode_r;
  assign sts.table_full = (count_r >= MAX_CNT);
  assign sts.sched_idle = (unfin_r == '0);
  assign sts.scan_hit   = !done_r[scan_idx_r];
  assign out_tdata      = out_r;

  always_ff @(posedge clk) begin
    if (cmd.do_add) burst_mem[add_idx] <= burst_r;
    if (cmd.mem_read) burst_rd_r <= burst_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.update) served_mem[scan_idx_r] <= served_new;
    if (cmd.mem_read) served_rd_r <= served_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= in_tuser;
      burst_r <= burst_in;
    end
    if (cmd.out_load) begin
      out_r <= {3'b000, clock_r, turn_r, wait_r,
                count_ext[fcfs_rr_pkg::COUNT_W-1:0], full_r, (unfin_r == '0),
                fin_r, granted_ext[fcfs_rr_pkg::GRANT_W-1:0], grant_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r      <= 1'b0;
      count_r    <= '0;
      nz_r       <= '0;
      unfin_r    <= '0;
      last_r     <= LAST_IDX;
      scan_idx_r <= '0;
      granted_r  <= '0;
      done_r     <= '0;
      zb_r       <= '0;
      touched_r  <= '0;
      clock_r    <= '0;
      wait_r     <= '0;
      turn_r     <= '0;
      grant_r    <= 1'b0;
      fin_r      <= 1'b0;
      full_r     <= 1'b0;
      fin_hit_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) alg_r <= cfg_wr_data;
      if (cmd.load_item) begin
        grant_r   <= 1'b0;
        granted_r <= '0;
        fin_r     <= 1'b0;
        full_r    <= 1'b0;
      end
      if (cmd.reject) full_r <= 1'b1;
      if (cmd.do_add) begin
        count_r   <= count_r + NW'(1);
        nz_r      <= nz_add;
        unfin_r   <= nz_add;
        zb_r      <= zb_add;
        done_r    <= zb_add;
        touched_r <= '0;
        last_r    <= LAST_IDX;
        clock_r   <= '0;
        wait_r    <= '0;
        turn_r    <= '0;
      end
      if (cmd.do_clear) begin
        count_r   <= '0;
        nz_r      <= '0;
        unfin_r   <= '0;
        touched_r <= '0;
        last_r    <= LAST_IDX;
        clock_r   <= '0;
        wait_r    <= '0;
        turn_r    <= '0;
      end
      if (cmd.scan_start) scan_idx_r <= start_idx;
      if (cmd.scan_step)  scan_idx_r <= step_next;
      if (cmd.update) begin
        touched_r[scan_idx_r] <= 1'b1;
        last_r    <= scan_idx_r;
        grant_r   <= 1'b1;
        granted_r <= scan_idx_r;
        clock_r   <= clock_inc;
        fin_hit_r <= (served_new == burst_rd_r);
      end
      if (cmd.sum && fin_hit_r) begin
        fin_r              <= 1'b1;
        done_r[scan_idx_r] <= 1'b1;
        unfin_r            <= unfin_r - NW'(1);
        turn_r             <= turn_sat;
        wait_r             <= wait_sat;
      end
    end
  end

endmodule
